// File: rtl/twio_pkg.sv
// ----------------------------------------------------------------------------
// twio_pkg: shared types and constants for the wheel and IMU odometry block
// Widths, fixed-point constants, the arctangent table and unit command types.
// ----------------------------------------------------------------------------
package twio_pkg;

   // Fixed-point format of sin and cos, and the length of the CORDIC run.
   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_OFFSET = 2'd1;

   // Yaw conversion: centidegrees to 65536 units per turn by long division.
   // An offset of 60000 units keeps the dividend positive.
   localparam int NUM_W   = 33;
   localparam int QUOT_W  = 18;
   localparam int REM_W   = 16;
   localparam logic [REM_W:0] DIVISOR = 17'd36000;
   localparam logic signed [34:0] YAW_NUM_OFFSET = 35'sd2160018000;
   localparam logic signed [18:0] U_OFFSET = 19'sd60000;

   // Serial multiply-accumulate widths.
   localparam int MAC_A_W = 40;
   localparam int MAC_B_W = 32;
   localparam int ACC_W   = 72;

   // Heading-unit-to-radians scale and rounding constants.
   localparam logic signed [MAC_A_W-1:0] TWO_PI_Q28 = 40'sd1686629713;
   localparam logic signed [ACC_W-1:0] BIAS_RAD   = 72'sd32768;
   localparam logic signed [ACC_W-1:0] BIAS_LEVER = 72'sd134217728;
   localparam logic signed [ACC_W-1:0] BIAS_ROT   = 72'sd1 <<< (FRAC_BITS - 1);

   // CORDIC widths and start vector.
   localparam int CS_W = FRAC_BITS + 4;
   localparam int Z_W  = 34;
   localparam int STEP_W = 5;
   localparam longint CORDIC_GAIN_Q30 = 64'd652032874;
   localparam logic signed [CS_W-1:0] CORDIC_K =
      CS_W'(CORDIC_GAIN_Q30 >> (30 - FRAC_BITS));
   localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sd1073741824;

   // Command to the multiply-accumulate unit.
   typedef struct packed {
      logic start;
      logic keep;
      logic negate;
   } mac_cmd_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MUL_R,
      ST_MUL_CX,
      ST_MUL_CY,
      ST_MUL_XC,
      ST_MUL_XS,
      ST_MUL_YS,
      ST_MUL_YC,
      ST_FINISH
   } state_type;

   // Arctangent of 2^-i in units of 2^32 per turn.
   function automatic logic [31:0] cordic_atan(input logic [STEP_W-1:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10679838;
         5'd7:    v = 32'd5340245;
         5'd8:    v = 32'd2670163;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         5'd21:   v = 32'd326;
         5'd22:   v = 32'd163;
         5'd23:   v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/twio_div.sv
// ----------------------------------------------------------------------------
// twio_div: restoring divider by a constant
// Produces one quotient bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module twio_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [twio_pkg::NUM_W-1:0]     numer,
   output logic [twio_pkg::QUOT_W-1:0]    quot,
   output logic                           done
);
   import twio_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [STEP_W-1:0]    cnt_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [QUOT_W-1:0]    num_ff;
   logic [QUOT_W-1:0]    quot_ff;
   logic [REM_W:0]       trial;
   logic                 qbit;

   // Bring down the next dividend bit and try the subtraction.
   always_comb begin
      trial = {rem_ff, num_ff[QUOT_W-1]};
      qbit  = (trial >= DIVISOR);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Remainder and quotient shift registers.
   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff  <= STEP_W'(QUOT_W - 1);
         rem_ff  <= REM_W'(numer[NUM_W-1:QUOT_W]);
         num_ff  <= numer[QUOT_W-1:0];
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         rem_ff  <= qbit ? REM_W'(trial - DIVISOR) : REM_W'(trial);
         num_ff  <= {num_ff[QUOT_W-2:0], 1'b0};
         quot_ff <= {quot_ff[QUOT_W-2:0], qbit};
      end
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

// File: rtl/twio_mac.sv
// ----------------------------------------------------------------------------
// twio_mac: bit-serial multiply-accumulate unit
// Adds or subtracts a times b into the accumulator, one bit of b per cycle.
// ----------------------------------------------------------------------------
module twio_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  twio_pkg::mac_cmd_type                 cmd,
   input  logic signed [twio_pkg::MAC_A_W-1:0]   a,
   input  logic signed [twio_pkg::MAC_B_W-1:0]   b,
   input  logic signed [twio_pkg::ACC_W-1:0]     bias,
   output logic signed [twio_pkg::ACC_W-1:0]     acc,
   output logic                                  done
);
   import twio_pkg::*;

   logic                     busy_ff;
   logic                     done_ff;
   logic                     neg_ff;
   logic [STEP_W-1:0]        cnt_ff;
   logic signed [ACC_W-1:0]  a_ff;
   logic [MAC_B_W-1:0]       b_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  term;
   logic                     last;
   logic                     sub;

   // The top bit of b carries negative weight.
   always_comb begin
      last = (cnt_ff == STEP_W'(MAC_B_W - 1));
      term = b_ff[0] ? a_ff : '0;
      sub  = neg_ff ^ last;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Operand shift registers and accumulator.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cnt_ff <= '0;
         neg_ff <= cmd.negate;
         a_ff   <= ACC_W'(a);
         b_ff   <= b;
         if (!cmd.keep) begin
            acc_ff <= bias;
         end
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         a_ff   <= a_ff <<< 1;
         b_ff   <= b_ff >> 1;
         acc_ff <= sub ? acc_ff - term : acc_ff + term;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("multiply started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiply done while still busy");
   a_fall_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff)
      else $error("multiply ended without done");
`endif

endmodule

// File: rtl/twio_cordic.sv
// ----------------------------------------------------------------------------
// twio_cordic: iterative CORDIC sine and cosine
// One rotation step per cycle on a folded angle of 2^32 units per turn.
// ----------------------------------------------------------------------------
module twio_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [31:0]                        angle,
   output logic signed [twio_pkg::CS_W-1:0]   cos_out,
   output logic signed [twio_pkg::CS_W-1:0]   sin_out,
   output logic                               busy
);
   import twio_pkg::*;

   logic                    busy_ff;
   logic                    flip_ff;
   logic [STEP_W-1:0]       step_ff;
   logic signed [CS_W-1:0]  x_ff;
   logic signed [CS_W-1:0]  y_ff;
   logic signed [Z_W-1:0]   z_ff;
   logic signed [Z_W-1:0]   za;
   logic                    fold;
   logic signed [CS_W-1:0]  xs;
   logic signed [CS_W-1:0]  ys;
   logic signed [CS_W-1:0]  x_in;
   logic signed [CS_W-1:0]  y_in;
   logic signed [Z_W-1:0]   z_in;
   logic signed [Z_W-1:0]   atan_ext;
   logic                    last;

   // Fold angles beyond a quarter turn by a half turn.
   always_comb begin
      za   = Z_W'($signed(angle));
      fold = (za > QUARTER_TURN) || (za < -QUARTER_TURN);
   end

   // One rotation step.
   always_comb begin
      xs       = x_ff >>> step_ff;
      ys       = y_ff >>> step_ff;
      atan_ext = $signed({2'b00, cordic_atan(step_ff)});
      last     = (step_ff == STEP_W'(CORDIC_STEPS - 1));
      if (z_ff >= 0) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - atan_ext;
      end else begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + atan_ext;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && last) begin
         busy_ff <= 1'b0;
      end
   end

   // Rotation registers; the fold is undone on the last step.
   always_ff @(posedge clock) begin
      if (start) begin
         step_ff <= '0;
         flip_ff <= fold;
         x_ff    <= CORDIC_K;
         y_ff    <= '0;
         z_ff    <= fold ? Z_W'($signed(angle ^ 32'h8000_0000)) : za;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         z_ff    <= z_in;
         if (last && flip_ff) begin
            x_ff <= -x_in;
            y_ff <= -y_in;
         end else begin
            x_ff <= x_in;
            y_ff <= y_in;
         end
      end
   end

   assign cos_out = x_ff;
   assign sin_out = y_ff;
   assign busy    = busy_ff;

endmodule

// File: rtl/two_wheel_imu_odometry.sv
// ----------------------------------------------------------------------------
// two_wheel_imu_odometry: pose tracking from two tracking wheels and IMU yaw
// Differences wheel distances and yaw, corrects the wheel deltas for the
// lever arms, rotates them by the accumulated heading and integrates.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  x_distance, y_distance, yaw_centideg
//   rsp      out        rsp_valid/rsp_stall  pose_x, pose_y, pose_heading
//   csr      in         csr_write            csr_index, csr_wdata
//
// From acceptance until the block can take the next item, an item passes through
// the yaw division, seven passes through the bit-serial multiplier (each a load
// and one step per bit of b) and the finish state; no new item is taken before
// it is done. The CORDIC runs alongside the multiplier and adds no time.
// Reset clears the pose, history and wheel offsets.
// The result sits in an output register; a new item is accepted while it
// waits, and the block holds only if the next result is ready first.
// ----------------------------------------------------------------------------
module two_wheel_imu_odometry (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [31:0]                  req_x_distance,
   input  logic signed [31:0]                  req_y_distance,
   input  logic signed [15:0]                  req_yaw_centideg,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_pose_x,
   output logic signed [31:0]                  rsp_pose_y,
   output logic signed [31:0]                  rsp_pose_heading,
   input  logic                                csr_write,
   input  logic [twio_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                         csr_wdata
);
   import twio_pkg::*;

   state_type               state_ff;
   state_type               state_in;

   logic signed [31:0]      x_off_ff;
   logic signed [31:0]      y_off_ff;
   logic signed [31:0]      xd_ff;
   logic signed [31:0]      yd_ff;
   logic signed [31:0]      last_x_ff;
   logic signed [31:0]      last_y_ff;
   logic signed [17:0]      last_heading_ff;
   logic signed [31:0]      heading_ff;
   logic signed [31:0]      pos_x_ff;
   logic signed [31:0]      pos_y_ff;
   logic signed [33:0]      r_ff;
   logic signed [36:0]      dx_ff;
   logic signed [36:0]      dy_ff;
   logic                    rsp_valid_ff;
   logic signed [31:0]      rsp_x_ff;
   logic signed [31:0]      rsp_y_ff;
   logic signed [31:0]      rsp_h_ff;

   logic                    div_start;
   logic [NUM_W-1:0]        div_numer;
   logic signed [34:0]      numer_wide;
   logic [QUOT_W-1:0]       quot;
   logic                    div_done;
   logic signed [18:0]      u_wide;
   logic signed [17:0]      u_calc;
   logic signed [18:0]      d_calc;
   logic signed [31:0]      heading_new;

   mac_cmd_type             mac_cmd;
   logic signed [MAC_A_W-1:0] mac_a;
   logic signed [MAC_B_W-1:0] mac_b;
   logic signed [ACC_W-1:0] mac_bias;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] acc_rot;
   logic                    mac_done;

   logic                    cordic_start;
   logic signed [CS_W-1:0]  cos_val;
   logic signed [CS_W-1:0]  sin_val;
   logic                    cordic_busy;

   logic signed [33:0]      r_calc;
   logic signed [35:0]      lever;
   logic signed [36:0]      delta_calc;
   logic signed [55:0]      w_calc;
   logic signed [56:0]      pos_x_sum;
   logic signed [56:0]      pos_y_sum;
   logic                    out_free;

   // Clamp a wide position to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [56:0] v);
      logic signed [31:0] r;
      if (v > 57'sd2147483647) begin
         r = 32'sh7fff_ffff;
      end else if (v < -57'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Yaw dividend, quotient offset and heading change.
   always_comb begin
      numer_wide  = (35'(req_yaw_centideg) <<< 16) + YAW_NUM_OFFSET;
      div_numer   = numer_wide[NUM_W-1:0];
      u_wide      = $signed({1'b0, quot}) - U_OFFSET;
      u_calc      = u_wide[17:0];
      d_calc      = 19'(u_calc) - 19'(last_heading_ff);
      heading_new = heading_ff + 32'(d_calc);
   end

   // Products taken out of the accumulator.
   always_comb begin
      r_calc     = acc[49:16];
      lever      = acc[63:28];
      acc_rot    = acc >>> FRAC_BITS;
      w_calc     = acc_rot[55:0];
      delta_calc = (state_ff == ST_MUL_CX)
                 ? 37'(xd_ff) - 37'(last_x_ff) + 37'(lever)
                 : 37'(yd_ff) - 37'(last_y_ff) + 37'(lever);
      pos_x_sum  = 57'(pos_x_ff) + 57'(w_calc);
      pos_y_sum  = 57'(pos_y_ff) + 57'(w_calc);
      out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Sequencer: next state and unit commands.
   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      cordic_start = 1'b0;
      mac_cmd      = '0;
      mac_a        = '0;
      mac_b        = '0;
      mac_bias     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               mac_cmd.start = 1'b1;
               mac_a         = TWO_PI_Q28;
               mac_b         = 32'(d_calc);
               mac_bias      = BIAS_RAD;
               cordic_start  = 1'b1;
               state_in      = ST_MUL_R;
            end
         end
         ST_MUL_R: begin
            if (mac_done) begin
               mac_cmd.start = 1'b1;
               mac_a         = 40'(r_calc);
               mac_b         = x_off_ff;
               mac_bias      = BIAS_LEVER;
               state_in      = ST_MUL_CX;
            end
         end
         ST_MUL_CX: begin
            if (mac_done) begin
               mac_cmd.start = 1'b1;
               mac_a         = 40'(r_ff);
               mac_b         = y_off_ff;
               mac_bias      = BIAS_LEVER;
               state_in      = ST_MUL_CY;
            end
         end
         ST_MUL_CY: begin
            if (mac_done) begin
               mac_cmd.start = 1'b1;
               mac_a         = 40'(dx_ff);
               mac_b         = 32'(cos_val);
               mac_bias      = BIAS_ROT;
               state_in      = ST_MUL_XC;
            end
         end
         ST_MUL_XC: begin
            if (mac_done) begin
               mac_cmd.start  = 1'b1;
               mac_cmd.keep   = 1'b1;
               mac_cmd.negate = 1'b1;
               mac_a          = 40'(dy_ff);
               mac_b          = 32'(sin_val);
               state_in       = ST_MUL_XS;
            end
         end
         ST_MUL_XS: begin
            if (mac_done) begin
               mac_cmd.start = 1'b1;
               mac_a         = 40'(dx_ff);
               mac_b         = 32'(sin_val);
               mac_bias      = BIAS_ROT;
               state_in      = ST_MUL_YS;
            end
         end
         ST_MUL_YS: begin
            if (mac_done) begin
               mac_cmd.start = 1'b1;
               mac_cmd.keep  = 1'b1;
               mac_a         = 40'(dy_ff);
               mac_b         = 32'(cos_val);
               state_in      = ST_MUL_YC;
            end
         end
         ST_MUL_YC: begin
            if (mac_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register, configuration, history and pose.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         x_off_ff        <= '0;
         y_off_ff        <= '0;
         last_x_ff       <= '0;
         last_y_ff       <= '0;
         last_heading_ff <= '0;
         heading_ff      <= '0;
         pos_x_ff        <= '0;
         pos_y_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_X_OFFSET: x_off_ff <= csr_wdata;
               CSR_Y_OFFSET: y_off_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_DIVIDE && div_done) begin
            last_heading_ff <= u_calc;
            heading_ff      <= heading_new;
         end
         if (state_ff == ST_MUL_CY && mac_done) begin
            last_x_ff <= xd_ff;
            last_y_ff <= yd_ff;
         end
         if (state_ff == ST_MUL_XS && mac_done) begin
            pos_x_ff <= sat32(pos_x_sum);
         end
         if (state_ff == ST_MUL_YC && mac_done) begin
            pos_y_ff <= sat32(pos_y_sum);
         end
         // A new result replaces a taken one in the same cycle.
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         xd_ff <= req_x_distance;
         yd_ff <= req_y_distance;
      end
      if (state_ff == ST_MUL_R && mac_done) begin
         r_ff <= r_calc;
      end
      if (state_ff == ST_MUL_CX && mac_done) begin
         dx_ff <= delta_calc;
      end
      if (state_ff == ST_MUL_CY && mac_done) begin
         dy_ff <= delta_calc;
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_x_ff <= pos_x_ff;
         rsp_y_ff <= pos_y_ff;
         rsp_h_ff <= heading_ff;
      end
   end

   // Units.
   twio_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .quot  (quot),
      .done  (div_done)
   );

   twio_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .a     (mac_a),
      .b     (mac_b),
      .bias  (mac_bias),
      .acc   (acc),
      .done  (mac_done)
   );

   twio_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   ({heading_new[15:0], 16'h0000}),
      .cos_out (cos_val),
      .sin_out (sin_val),
      .busy    (cordic_busy)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pose_x       = rsp_x_ff;
   assign rsp_pose_y       = rsp_y_ff;
   assign rsp_pose_heading = rsp_h_ff;

`ifndef SYNTHESIS
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result loaded outside the finish state");
   a_cordic_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_CY && mac_done) |-> !cordic_busy)
      else $error("rotation started before sine and cosine were ready");
   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (u_calc <= 18'sd59653) && (u_calc >= -18'sd59653))
      else $error("converted yaw out of range");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the wheel and IMU odometry block
// Drives wheel distances and yaw items through random idling and stalls,
// predicts each pose with a local fixed-point model and checks every field.
// ----------------------------------------------------------------------------
module tb_top;
   import twio_pkg::*;

   typedef struct packed {
      logic signed [31:0] x_dist;
      logic signed [31:0] y_dist;
      logic signed [15:0] yaw;
   } wheel_item_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] hd;
   } pose_type;

   // Register index that maps to no register.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_x_distance = '0;
   logic signed [31:0] req_y_distance = '0;
   logic signed [15:0] req_yaw_centideg = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_pose_x;
   logic signed [31:0] rsp_pose_y;
   logic signed [31:0] rsp_pose_heading;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   two_wheel_imu_odometry DUT (.*);

   // Odometry state mirrored by the predictor.
   logic signed [31:0] lever_x, lever_y;
   logic signed [31:0] prev_x, prev_y, prev_units;
   logic signed [31:0] odo_x, odo_y, heading_acc;

   wheel_item_type pending_items[$];
   pose_type expected_poses[$];
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatch_count = 0;
   bit driver_busy;

   initial begin
      forever #2 clock = ~clock;
   end

   // Arithmetic floor shift on 64-bit signed values.
   function automatic longint fshift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // CORDIC sin and cos of a 2^32-per-turn angle, Q(FRAC_BITS) results.
   task automatic heading_sincos(input logic [31:0] ang, output longint c,
                                 output longint s);
      longint z, x, y, xs, ys;
      bit flip;
      z = longint'(signed'(ang));
      flip = 0;
      if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
         z = longint'(signed'(ang ^ 32'h80000000));
         flip = 1;
      end
      x = fshift(64'sd652032874, 30 - FRAC_BITS);
      y = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         xs = fshift(x, i);
         ys = fshift(y, i);
         if (z >= 0) begin
            x = x - ys; y = y + xs; z -= longint'(cordic_atan(i[4:0]));
         end else begin
            x = x + ys; y = y - xs; z += longint'(cordic_atan(i[4:0]));
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   // Advance the odometry by one item and return the new pose.
   task automatic predict_pose(input wheel_item_type it, output pose_type p);
      longint cd, num, u, d, r, cx, cy, dx, dy, c, s, wx, wy;
      cd = longint'(it.yaw);
      num = cd * 65536 + 18000;
      u = num / 36000;
      if (num % 36000 != 0 && num < 0) u = u - 1;
      d = u - longint'(prev_units);
      r = fshift(d * 64'sd1686629713 + (64'sd1 <<< 15), 16);
      cx = fshift(longint'(lever_x) * r + (64'sd1 <<< 27), 28);
      cy = fshift(longint'(lever_y) * r + (64'sd1 <<< 27), 28);
      dx = longint'(it.x_dist) - longint'(prev_x) + cx;
      dy = longint'(it.y_dist) - longint'(prev_y) + cy;
      prev_x = it.x_dist;
      prev_y = it.y_dist;
      prev_units = u[31:0];
      heading_acc = heading_acc + d[31:0];
      heading_sincos({heading_acc[15:0], 16'h0}, c, s);
      wx = fshift(dx * c - dy * s + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS);
      wy = fshift(dx * s + dy * c + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS);
      odo_x = clamp32(longint'(odo_x) + wx);
      odo_y = clamp32(longint'(odo_y) + wy);
      p.px = odo_x;
      p.py = odo_y;
      p.hd = heading_acc;
   endtask

   // Driver: presents queued items, holds them while stalled.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall) begin
            // Hold the stalled item.
         end else if (pending_items.size() > 0 &&
                      $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_x_distance <= pending_items[0].x_dist;
            req_y_distance <= pending_items[0].y_dist;
            req_yaw_centideg <= pending_items[0].yaw;
            void'(pending_items.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Track whether the driver still holds an item not yet accepted.
   always_comb driver_busy = req_valid;

   // Request acceptance: predict the pose for each item taken.
   always @(posedge clock) begin
      pose_type p;
      if (!reset && req_valid && !req_stall) begin
         predict_pose('{req_x_distance, req_y_distance, req_yaw_centideg}, p);
         expected_poses.push_back(p);
      end
   end

   // Monitor: compare each accepted pose against the oldest expectation.
   always @(posedge clock) begin
      pose_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_poses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected pose x=%0d y=%0d h=%0d", rsp_pose_x,
                        rsp_pose_y, rsp_pose_heading);
         end else begin
            e = expected_poses.pop_front();
            if (e.px !== rsp_pose_x || e.py !== rsp_pose_y ||
                e.hd !== rsp_pose_heading) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Pose mismatch: exp x=%0d y=%0d h=%0d got x=%0d y=%0d h=%0d",
                           e.px, e.py, e.hd, rsp_pose_x, rsp_pose_y,
                           rsp_pose_heading);
            end
         end
      end
   end

   // Register writes, only while the block is idle.
   task automatic write_lever(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [31:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_X_OFFSET) lever_x = val;
      else if (idx == CSR_Y_OFFSET) lever_y = val;
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || driver_busy || expected_poses.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_yaw();
      int k = $urandom_range(99);
      if (k < 80) return 16'(int'($urandom_range(36000)) - 18000);
      if (k < 90) return 16'($urandom());
      return ($urandom_range(1)) ? 16'sd18000 : -16'sd18000;
   endfunction

   // Smooth motion with occasional jumps and full random noise.
   task automatic queue_random(input int n);
      logic signed [31:0] xd, yd;
      logic signed [15:0] yw;
      xd = $urandom(); yd = $urandom(); yw = pick_yaw();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 7) begin
            xd = xd + 32'(int'($urandom_range(131072)) - 65536);
            yd = yd + 32'(int'($urandom_range(131072)) - 65536);
            yw = yw + 16'(int'($urandom_range(400)) - 200);
            if (yw > 18000 || yw < -18000) yw = pick_yaw();
         end else begin
            xd = $urandom(); yd = $urandom(); yw = pick_yaw();
         end
         pending_items.push_back('{xd, yd, yw});
      end
   endtask

   // Stimulus sequence.
   initial begin
      int idle_tab[4] = '{0, 65, 0, 28};
      int stall_tab[4] = '{0, 0, 65, 28};
      lever_x = 0; lever_y = 0; prev_x = 0; prev_y = 0; prev_units = 0;
      odo_x = 0; odo_y = 0; heading_acc = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, seam crossings, out-of-range yaw.
      pending_items.push_back('{32'sh7fffffff, 32'sh80000000, 16'sd0});
      pending_items.push_back('{32'sh80000000, 32'sh7fffffff, 16'sd18000});
      pending_items.push_back('{32'sh0, 32'sh0, -16'sd18000});
      pending_items.push_back('{32'sh10000, 32'sh20000, 16'sd9000});
      pending_items.push_back('{32'sh10000, 32'sh20000, -16'sd9000});
      pending_items.push_back('{32'shffffffff, 32'sh1, 16'sh7fff});
      pending_items.push_back('{32'sh1, 32'shffffffff, 16'sh8000});
      pending_items.push_back('{32'sh7fffffff, 32'sh7fffffff, 16'sd1});
      pending_items.push_back('{32'sh7fffffff, 32'sh7fffffff, 16'sd0});
      wait_drained();
      write_lever(CSR_X_OFFSET, 32'h7fffffff);
      write_lever(CSR_Y_OFFSET, 32'h80000000);
      write_lever(CSR_UNUSED, 32'h12345678);
      pending_items.push_back('{32'sh0, 32'sh0, 16'sd18000});
      pending_items.push_back('{32'sh0, 32'sh0, -16'sd18000});
      pending_items.push_back('{32'sh100, 32'sh100, 16'sh7fff});
      pending_items.push_back('{32'sh200, 32'shffff0000, 16'sh8000});
      wait_drained();

      // Random phases across offsets and idling mixes.
      for (int ph = 0; ph < 8; ph++) begin
         sender_idle_pct = idle_tab[ph % 4];
         receiver_stall_pct = stall_tab[ph % 4];
         case (ph % 4)
            0: begin write_lever(CSR_X_OFFSET, 32'h0);
                     write_lever(CSR_Y_OFFSET, 32'h0); end
            1: begin write_lever(CSR_X_OFFSET, 32'h80000000);
                     write_lever(CSR_Y_OFFSET, 32'h7fffffff); end
            default: begin write_lever(CSR_X_OFFSET, $urandom_range(0, 32'h7ffff) - 32'h40000);
                     write_lever(CSR_Y_OFFSET, $urandom()); end
         endcase
         queue_random(200);
         wait_drained();
      end

      if (mismatch_count == 0 && expected_poses.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Run limit: ~1620 items with heavy idling.
   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
